// File: rtl/gmcp_pkg.sv
// Shared types and constants for the gaussian mask complex pixel block.
// No dependencies; used by every module of the block and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package gmcp_pkg;

	// Field and register widths
	localparam int unsigned GMCP_PIXEL_W = 32;
	localparam int unsigned POS_W        = 12;
	localparam int unsigned DIM_MAX      = 4096;
	localparam int unsigned CTR_W        = 20;
	localparam int unsigned SHP_W        = 32;
	localparam int unsigned FILL_W       = 64;
	localparam int unsigned DATA_W       = 64;
	localparam int unsigned IDX_W        = 3;

	// Exponential series: remainder, term and partial sum in Q.32
	localparam int unsigned SER_W = 32;
	localparam int unsigned SUM_W = 33;
	localparam int unsigned WGT_W = 17;

	localparam logic [SER_W-1:0] LN2_Q32 = 32'd2977044472;
	localparam logic [SUM_W-1:0] SUM_ONE = 33'h1_0000_0000;
	localparam logic [WGT_W-1:0] WGT_ONE = 17'h1_0000;

	// Octave estimate n ~ (s >> SHI_LSB) * N_RECIP >> N_SHIFT, low by at most one
	localparam int unsigned SHI_LSB = 20;
	localparam int unsigned N_SHIFT = 20;
	localparam logic [8:0]  N_RECIP = 9'((64'd1 << (SHI_LSB + N_SHIFT)) / 64'(LN2_Q32));

	// Pipeline depth
	localparam int unsigned FRONT_STAGES = 10;
	localparam int unsigned TERM_STAGES  = 4;
	localparam int unsigned NUM_TERMS    = 11;
	localparam int unsigned BACK_STAGES  = 6;
	localparam int unsigned GMCP_LATENCY = FRONT_STAGES + TERM_STAGES * NUM_TERMS + BACK_STAGES;

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_SHAPE_M00 = 3'd2,
		REG_SHAPE_M01 = 3'd3,
		REG_SHAPE_M10 = 3'd4,
		REG_SHAPE_M11 = 3'd5,
		REG_INVERT = 3'd6,
		REG_FILL = 3'd7
	} gmcp_reg_e;

	// State of the series between term units; term is not yet folded into sum
	typedef struct packed {
		logic             valid;
		logic [SER_W-1:0] r;
		logic [SER_W-1:0] term;
		logic [SUM_W-1:0] sum;
	} gmcp_ser_t;

endpackage

`default_nettype wire

// File: rtl/gmcp_exp_term.sv
// One term of the exp(-r) Taylor series: term_k = ((term * r) >> 32) / K.
// Four register stages. Depends on gmcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmcp_exp_term
	import gmcp_pkg::*;
#(
	parameter int unsigned K      = 2,
	parameter int unsigned SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  gmcp_ser_t              ser_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output gmcp_ser_t              ser_out,
	output logic      [SIDE_W-1:0] side_out
);

	localparam int unsigned      C        = $clog2(K);
	localparam logic [SER_W-1:0] RK       = SER_W'((64'd1 << (31 + C)) / 64'(K));
	localparam logic [SER_W-1:0] K_W      = SER_W'(K);
	localparam bit               SUB_PREV = ((K - 1) % 2) == 1;

	logic [3:0] v_q;

	logic [63:0]       prod_s1;
	logic [SUM_W-1:0]  sum_s1, sum_s2, sum_s3, sum_s4;
	logic [SER_W-1:0]  r_s1, r_s2, r_s3, r_s4;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4;
	logic [SER_W-1:0]  x_s2, x_s3;
	logic [63:0]       y_s2;
	logic [SER_W-1:0]  q_s3, qk_s3;
	logic [SER_W-1:0]  term_s4;
	logic [SER_W-1:0]  q_est, rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[2:0], ser_in.valid};
		end
	end

	// estimate is exact or one low; rem >= K fixes it
	assign q_est = SER_W'(y_s2 >> (31 + C));
	assign rem   = x_s3 - qk_s3;

	always_ff @(posedge clk) begin
		// s1: product, and fold the previous term into the sum
		prod_s1 <= 64'(ser_in.term) * 64'(ser_in.r);
		sum_s1  <= SUB_PREV ? ser_in.sum - SUM_W'(ser_in.term)
		                    : ser_in.sum + SUM_W'(ser_in.term);
		r_s1    <= ser_in.r;
		side_s1 <= side_in;
		// s2: reciprocal multiply for the divide by K
		x_s2    <= prod_s1[63:32];
		y_s2    <= 64'(prod_s1[63:32]) * 64'(RK);
		sum_s2  <= sum_s1;
		r_s2    <= r_s1;
		side_s2 <= side_s1;
		// s3
		x_s3    <= x_s2;
		q_s3    <= q_est;
		qk_s3   <= SER_W'(q_est * K_W);
		sum_s3  <= sum_s2;
		r_s3    <= r_s2;
		side_s3 <= side_s2;
		// s4: correction
		term_s4 <= q_s3 + SER_W'(rem >= K_W);
		sum_s4  <= sum_s3;
		r_s4    <= r_s3;
		side_s4 <= side_s3;
	end

	assign ser_out.valid = v_q[3];
	assign ser_out.r     = r_s4;
	assign ser_out.term  = term_s4;
	assign ser_out.sum   = sum_s4;
	assign side_out      = side_s4;

endmodule

`default_nettype wire

// File: rtl/gaussian_mask_complex_pixel_top.sv
// Top level of the gaussian mask for complex pixels: weight pipeline and blend.
// Depends on gmcp_pkg and gmcp_exp_term.
//
// Channel  Dir  Transaction when          Payload
// -------  ---  ------------------------  ------------------------------
// start    in   start high, busy low      col, row, in_real, in_imag
// result   out  done high (one cycle)     out_real, out_imag
// config   in   wr_en high                wr_index, wr_data
//
// Fully pipelined: one pixel transaction per cycle, busy is always low.
// Most of the pipeline is the exp series: eleven term units of four
// stages each, behind ten stages of position math and in front of six
// stages of weight rounding and blending.
// arst_n clears the valid bits and all configuration registers to zero.
// Results cannot be held off; done marks each one for a single cycle.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_mask_complex_pixel_top
	import gmcp_pkg::*;
#(
	parameter int unsigned PIXEL_WIDTH = GMCP_PIXEL_W
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// pixel transactions
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic        [POS_W-1:0]       col,
	input  wire logic        [POS_W-1:0]       row,
	input  wire logic signed [PIXEL_WIDTH-1:0] in_real,
	input  wire logic signed [PIXEL_WIDTH-1:0] in_imag,
	// results
	output logic                               done,
	output logic signed      [PIXEL_WIDTH-1:0] out_real,
	output logic signed      [PIXEL_WIDTH-1:0] out_imag,
	// configuration writes
	input  wire logic                          wr_en,
	input  wire logic        [IDX_W-1:0]       wr_index,
	input  wire logic        [DATA_W-1:0]      wr_data
);

	// Widths of the datapath
	localparam int unsigned DIFF_W = ((PIXEL_WIDTH > 32) ? PIXEL_WIDTH : 32) + 1;
	localparam int unsigned DX_W   = CTR_W + 1;           // signed offset, 8 frac bits
	localparam int unsigned PRD_W  = SHP_W + DX_W;        // matrix product
	localparam int unsigned Q_W    = PRD_W + 1;           // q, 32 frac bits
	localparam int unsigned RNG_B  = 34;                  // |q| < 4 in Q.32
	localparam int unsigned H_LSB  = 16;
	localparam int unsigned H_W    = RNG_B - H_LSB;       // |q| truncated to Q.16
	localparam int unsigned SQ_W   = 2 * H_W;
	localparam int unsigned S_W    = SQ_W + 1;
	localparam int unsigned NP_W   = (SQ_W - SHI_LSB) + 9;
	localparam int unsigned N_W    = 5;                    // octave count, 0..23
	localparam int unsigned NL_W   = SQ_W;
	localparam int unsigned R0_W   = SER_W + 1;
	localparam int unsigned T_W    = 40;
	localparam int unsigned SH_W   = 6;
	localparam int unsigned SIDE_W = 1 + N_W + 2 * DIFF_W;
	localparam int unsigned MUL_W  = DIFF_W + WGT_W + 1;
	localparam int unsigned RND_W  = MUL_W - 16;
	localparam int unsigned V_W    = RND_W + 1;

	localparam logic [POS_W-1:0]        COL_MAX  = POS_W'(DIM_MAX - 1);
	localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(32768);
	localparam logic signed [V_W-1:0]   LIM_HI   =
		V_W'((64'sd1 <<< (PIXEL_WIDTH - 1)) - 64'sd1);
	localparam logic signed [V_W-1:0]   LIM_LO   = -LIM_HI - V_W'(1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic        [CTR_W-1:0]  center_x_q, center_y_q;
	logic signed [SHP_W-1:0]  m00_q, m01_q, m10_q, m11_q;
	logic                     invert_q;
	logic        [FILL_W-1:0] fill_q;
	logic signed [31:0]       fre, fim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			m00_q      <= '0;
			m01_q      <= '0;
			m10_q      <= '0;
			m11_q      <= '0;
			invert_q   <= 1'b0;
			fill_q     <= '0;
		end else if (wr_en) begin
			unique case (gmcp_reg_e'(wr_index))
				REG_CENTER_X:  center_x_q <= wr_data[CTR_W-1:0];
				REG_CENTER_Y:  center_y_q <= wr_data[CTR_W-1:0];
				REG_SHAPE_M00: m00_q      <= wr_data[SHP_W-1:0];
				REG_SHAPE_M01: m01_q      <= wr_data[SHP_W-1:0];
				REG_SHAPE_M10: m10_q      <= wr_data[SHP_W-1:0];
				REG_SHAPE_M11: m11_q      <= wr_data[SHP_W-1:0];
				REG_INVERT:    invert_q   <= wr_data[0];
				REG_FILL:      fill_q     <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign fre = $signed(fill_q[63:32]);
	assign fim = $signed(fill_q[31:0]);

	// ------------------------------------------------------------------
	// Valid bits: the pipeline never stalls, so they simply shift
	// ------------------------------------------------------------------
	logic                    accept;
	logic [FRONT_STAGES-1:0] fv_q;
	logic [BACK_STAGES-1:0]  bv_q;
	gmcp_ser_t               ser_c  [NUM_TERMS+1];
	logic [SIDE_W-1:0]       side_c [NUM_TERMS+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
			bv_q <= '0;
		end else begin
			fv_q <= {fv_q[FRONT_STAGES-2:0], accept};
			bv_q <= {bv_q[BACK_STAGES-2:0], ser_c[NUM_TERMS].valid};
		end
	end

	// ------------------------------------------------------------------
	// Front: position offset, shaping matrix, sum of squares, range split
	// ------------------------------------------------------------------
	logic [POS_W-1:0]          col_c, row_c;
	logic signed [DX_W-1:0]    dx_s1, dy_s1;
	logic [2*DIFF_W-1:0]       dif_s1;
	logic [2*DIFF_W-1:0]       dif_dly_q [FRONT_STAGES-1];
	logic signed [PRD_W-1:0]   p00_s2, p01_s2, p10_s2, p11_s2;
	logic signed [Q_W-1:0]     q0_s3, q1_s3;
	logic [Q_W-1:0]            mag0, mag1;
	logic [H_W-1:0]            h0_s4, h1_s4;
	logic                      big_s4, big_s5;
	logic [SQ_W-1:0]           sq0_s5, sq1_s5;
	logic [S_W-1:0]            ssum;
	logic [SQ_W-1:0]           s_s6, s_s7, s_s8;
	logic                      zero_s6, zero_s7, zero_s8, zero_s9, zero_s10;
	logic [NP_W-1:0]           nprod;
	logic [N_W-1:0]            n_s7, n_s8, n_s9, n_s10;
	logic [NL_W-1:0]           nl_s8;
	logic [R0_W-1:0]           r0_s9;
	logic [SER_W-1:0]          r_s10;

	assign col_c = (32'(col) >= 32'(DIM_MAX)) ? COL_MAX : col;
	assign row_c = (32'(row) >= 32'(DIM_MAX)) ? COL_MAX : row;

	assign mag0 = q0_s3[Q_W-1] ? Q_W'(-q0_s3) : Q_W'(q0_s3);
	assign mag1 = q1_s3[Q_W-1] ? Q_W'(-q1_s3) : Q_W'(q1_s3);
	assign ssum = S_W'(sq0_s5) + S_W'(sq1_s5);
	assign nprod = NP_W'(s_s6[SQ_W-1:SHI_LSB]) * NP_W'(N_RECIP);

	always_ff @(posedge clk) begin
		// s1: offset from center (8 fraction bits), pixel minus fill
		dx_s1  <= $signed({1'b0, col_c, {(CTR_W-POS_W){1'b0}}}) - $signed({1'b0, center_x_q});
		dy_s1  <= $signed({1'b0, row_c, {(CTR_W-POS_W){1'b0}}}) - $signed({1'b0, center_y_q});
		dif_s1 <= {DIFF_W'(in_real) - DIFF_W'(fre), DIFF_W'(in_imag) - DIFF_W'(fim)};
		// s2: matrix products
		p00_s2 <= PRD_W'(m00_q) * PRD_W'(dx_s1);
		p01_s2 <= PRD_W'(m01_q) * PRD_W'(dy_s1);
		p10_s2 <= PRD_W'(m10_q) * PRD_W'(dx_s1);
		p11_s2 <= PRD_W'(m11_q) * PRD_W'(dy_s1);
		// s3
		q0_s3  <= Q_W'(p00_s2) + Q_W'(p01_s2);
		q1_s3  <= Q_W'(p10_s2) + Q_W'(p11_s2);
		// s4: |q| >= 4 forces a zero weight
		h0_s4  <= mag0[RNG_B-1:H_LSB];
		h1_s4  <= mag1[RNG_B-1:H_LSB];
		big_s4 <= (mag0[Q_W-1:RNG_B] != '0) || (mag1[Q_W-1:RNG_B] != '0);
		// s5
		sq0_s5 <= SQ_W'(h0_s4) * SQ_W'(h0_s4);
		sq1_s5 <= SQ_W'(h1_s4) * SQ_W'(h1_s4);
		big_s5 <= big_s4;
		// s6: s >= 16 also forces zero
		s_s6    <= ssum[SQ_W-1:0];
		zero_s6 <= big_s5 | ssum[S_W-1];
		// s7: octave estimate
		n_s7    <= nprod[NP_W-1:N_SHIFT];
		s_s7    <= s_s6;
		zero_s7 <= zero_s6;
		// s8
		nl_s8   <= NL_W'(n_s7) * NL_W'(LN2_Q32);
		n_s8    <= n_s7;
		s_s8    <= s_s7;
		zero_s8 <= zero_s7;
		// s9: remainder below 2*ln2
		r0_s9   <= R0_W'(s_s8 - nl_s8);
		n_s9    <= n_s8;
		zero_s9 <= zero_s8;
		// s10: final octave correction
		if (r0_s9 >= R0_W'(LN2_Q32)) begin
			r_s10 <= SER_W'(r0_s9 - R0_W'(LN2_Q32));
			n_s10 <= n_s9 + N_W'(1);
		end else begin
			r_s10 <= SER_W'(r0_s9);
			n_s10 <= n_s9;
		end
		zero_s10 <= zero_s9;
		// pixel differences ride alongside
		dif_dly_q[0] <= dif_s1;
		for (int i = 1; i < FRONT_STAGES - 1; i++) begin
			dif_dly_q[i] <= dif_dly_q[i-1];
		end
	end

	// ------------------------------------------------------------------
	// exp(-r): 1 - r already seeded, terms k = 2..12 in their own units
	// ------------------------------------------------------------------
	assign ser_c[0].valid = fv_q[FRONT_STAGES-1];
	assign ser_c[0].r     = r_s10;
	assign ser_c[0].term  = r_s10;
	assign ser_c[0].sum   = SUM_ONE;
	assign side_c[0]      = {zero_s10, n_s10, dif_dly_q[FRONT_STAGES-2]};

	for (genvar g = 0; g < NUM_TERMS; g++) begin : g_term
		gmcp_exp_term #(
			.K      (g + 2),
			.SIDE_W (SIDE_W)
		) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.ser_in   (ser_c[g]),
			.side_in  (side_c[g]),
			.ser_out  (ser_c[g+1]),
			.side_out (side_c[g+1])
		);
	end

	// ------------------------------------------------------------------
	// Back: fold last term, scale by 2^-(16+n), invert, blend, saturate
	// ------------------------------------------------------------------
	logic                       zero_x;
	logic [N_W-1:0]             n_x;
	logic [2*DIFF_W-1:0]        dif_x;
	logic [SUM_W-1:0]           e_s55;
	logic                       zero_s55, zero_s56;
	logic [N_W-1:0]             n_s55, n_s56;
	logic [2*DIFF_W-1:0]        dif_s55, dif_s56, dif_s57;
	logic [T_W-1:0]             t_s56;
	logic [WGT_W-1:0]           wraw, wsel, f_s57;
	logic signed [DIFF_W-1:0]   dre57, dim57;
	logic signed [MUL_W-1:0]    pre_re_s58, pre_im_s58;
	logic signed [RND_W-1:0]    rnd_re_s59, rnd_im_s59;
	logic signed [V_W-1:0]      vre, vim, sre, sim;
	logic [PIXEL_WIDTH-1:0]     ore_s60, oim_s60;

	assign {zero_x, n_x, dif_x} = side_c[NUM_TERMS];

	assign wraw  = WGT_W'(t_s56 >> (SH_W'(n_s56) + SH_W'(16)));
	assign wsel  = zero_s56 ? '0 : wraw;
	assign dre57 = $signed(dif_s57[2*DIFF_W-1:DIFF_W]);
	assign dim57 = $signed(dif_s57[DIFF_W-1:0]);
	assign vre   = V_W'(rnd_re_s59) + V_W'(fre);
	assign vim   = V_W'(rnd_im_s59) + V_W'(fim);

	always_comb begin
		if (vre > LIM_HI) begin
			sre = LIM_HI;
		end else if (vre < LIM_LO) begin
			sre = LIM_LO;
		end else begin
			sre = vre;
		end
		if (vim > LIM_HI) begin
			sim = LIM_HI;
		end else if (vim < LIM_LO) begin
			sim = LIM_LO;
		end else begin
			sim = vim;
		end
	end

	always_ff @(posedge clk) begin
		// s55: last term is even, so it adds
		e_s55    <= ser_c[NUM_TERMS].sum + SUM_W'(ser_c[NUM_TERMS].term);
		zero_s55 <= zero_x;
		n_s55    <= n_x;
		dif_s55  <= dif_x;
		// s56: round half up at bit 16+n
		t_s56    <= T_W'(e_s55) + (T_W'(1) << (SH_W'(n_s55) + SH_W'(15)));
		zero_s56 <= zero_s55;
		n_s56    <= n_s55;
		dif_s56  <= dif_s55;
		// s57: weight in Q1.16
		f_s57    <= invert_q ? WGT_ONE - wsel : wsel;
		dif_s57  <= dif_s56;
		// s58
		pre_re_s58 <= MUL_W'(dre57) * MUL_W'($signed({1'b0, f_s57}));
		pre_im_s58 <= MUL_W'(dim57) * MUL_W'($signed({1'b0, f_s57}));
		// s59: floor((x + 2^15) / 2^16)
		rnd_re_s59 <= RND_W'((pre_re_s58 + RND_HALF) >>> 16);
		rnd_im_s59 <= RND_W'((pre_im_s58 + RND_HALF) >>> 16);
		// s60
		ore_s60 <= sre[PIXEL_WIDTH-1:0];
		oim_s60 <= sim[PIXEL_WIDTH-1:0];
	end

	assign done     = bv_q[BACK_STAGES-1];
	assign out_real = ore_s60;
	assign out_imag = oim_s60;

endmodule

`default_nettype wire

// File: rtl/gmcp_checker.sv
// Port-level checks for the gaussian mask complex pixel top, bound to it below.
// Depends on gmcp_pkg and gaussian_mask_complex_pixel_top.
`timescale 1ns / 1ps
`default_nettype none

module gmcp_checker
	import gmcp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// every accepted transaction comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##GMCP_LATENCY done)
		else $error("result missing after accepted pixel");

	// no result without a transaction that caused it
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, GMCP_LATENCY))
		else $error("result without matching pixel");

	// reset empties the pipeline
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !done)
		else $error("result strobe during reset");

endmodule

bind gaussian_mask_complex_pixel_top gmcp_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
